>>> src/kct_pkg.sv
// ----------------------------------------------------------------------------
// Keyed count table package
// Shared constants, request codes and sequencer states.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;
   localparam int KEY_W = 16;
   localparam int CNT_W = 32;
   localparam int ENTRY_W = 1 + KEY_W + CNT_W;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_SUB   = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

>>> src/keyed_count_table_unit.sv
// ----------------------------------------------------------------------------
// Keyed count table unit
// Associative table of key and count entries with add, subtract, query and
// clear requests, held in one synchronous RAM.
// ----------------------------------------------------------------------------
// An add, subtract or query item reads every table entry once through the
// single RAM read port; an add or subtract then writes back at most once and
// a query writes nothing. Its result strobe comes in the first cycle in which
// busy is low again. A clear item gives its result strobe in the next cycle
// and keeps busy high while the RAM write port sweeps the valid bits. After
// reset the same sweep runs before the first item is taken. The receiver cannot
// stall: each result is on the rsp_ ports for exactly one cycle.
module keyed_count_table_unit
#(
   parameter int TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_type,
   input  logic [kct_pkg::KEY_W-1:0]  req_item_key,
   input  logic signed [kct_pkg::CNT_W-1:0] req_amount,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic                       rsp_enough,
   output logic signed [kct_pkg::CNT_W-1:0] rsp_count_now,
   output logic                       rsp_full_drop
);

   import kct_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);
   localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

   state_type state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [1:0]           op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [CNT_W-1:0]     amt_ff, amt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]     hit_cnt_ff, hit_cnt_in;
   logic                 free_ff, free_in;
   logic [AW-1:0]        free_idx_ff, free_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_enough_ff, rsp_enough_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                 rsp_drop_ff, rsp_drop_in;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;

   logic                 rd_entry_valid;
   logic [KEY_W-1:0]     rd_entry_key;
   logic [CNT_W-1:0]     rd_entry_count;
   logic [CNT_W-1:0]     sum_val;
   logic [CNT_W-1:0]     diff_val;
   logic                 accept;

   kct_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign rd_entry_valid = ram_rd_data[ENTRY_W-1];
   assign rd_entry_key   = ram_rd_data[CNT_W +: KEY_W];
   assign rd_entry_count = ram_rd_data[CNT_W-1:0];

   assign sum_val  = hit_cnt_ff + amt_ff;
   assign diff_val = hit_cnt_ff - amt_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_type == REQ_CLEAR) ? ST_CLEAR : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_END) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_cnt_in    = hit_cnt_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_enough_in = 1'b0;
      rsp_count_in  = '0;
      rsp_drop_in   = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cnt_ff[AW-1:0];
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cnt_ff[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            cnt_in    = cnt_ff + CW'(1);
         end
         ST_IDLE: begin
            cnt_in   = '0;
            found_in = 1'b0;
            free_in  = 1'b0;
            if (accept) begin
               op_in  = req_type;
               key_in = req_item_key;
               amt_in = req_amount;
               if (req_type == REQ_CLEAR) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CNT_END) begin
               ram_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[AW-1:0];
               cnt_in    = cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (rd_entry_valid && rd_entry_key == key_ff && !found_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_cnt_in = rd_entry_count;
               end
               if (!rd_entry_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            case (op_ff)
               REQ_ADD: begin
                  if (found_ff) begin
                     ram_wr_en    = 1'b1;
                     ram_wr_addr  = hit_idx_ff;
                     ram_wr_data  = {1'b1, key_ff, sum_val};
                     rsp_hit_in   = 1'b1;
                     rsp_count_in = sum_val;
                  end else if (free_ff) begin
                     ram_wr_en    = 1'b1;
                     ram_wr_addr  = free_idx_ff;
                     ram_wr_data  = {1'b1, key_ff, amt_ff};
                     rsp_count_in = amt_ff;
                  end else begin
                     rsp_drop_in = 1'b1;
                  end
               end
               REQ_SUB: begin
                  if (found_ff) begin
                     ram_wr_en    = 1'b1;
                     ram_wr_addr  = hit_idx_ff;
                     ram_wr_data  = {(diff_val != '0), key_ff, diff_val};
                     rsp_hit_in   = 1'b1;
                     rsp_count_in = diff_val;
                  end
               end
               REQ_QUERY: begin
                  if (found_ff) begin
                     rsp_hit_in    = 1'b1;
                     rsp_count_in  = hit_cnt_ff;
                     rsp_enough_in = ($signed(hit_cnt_ff) >= $signed(amt_ff));
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      rd_idx_ff     <= rd_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_cnt_ff    <= hit_cnt_in;
      free_idx_ff   <= free_idx_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_enough_ff <= rsp_enough_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_enough    = rsp_enough_ff;
   assign rsp_count_now = rsp_count_ff;
   assign rsp_full_drop = rsp_drop_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after an accepted item");

   a_drop_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_drop |-> !rsp_hit && rsp_count_now == '0)
      else $error("full drop reported together with a hit or a count");

   a_enough_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enough |-> rsp_hit)
      else $error("enough reported for an absent key");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid && !busy)
      else $error("result strobe missing after the write-back cycle");

endmodule

>>> src/kct_ram.sv
// ----------------------------------------------------------------------------
// Keyed count table RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module kct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
